/* sv/pla_pkg.sv */
package pla_pkg;

    localparam int REF_W     = 32;
    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int Q_DEPTH   = 2;

    typedef enum logic [3:0] {
        MODE_POINT     = 4'd0,
        MODE_LINE      = 4'd1,
        MODE_LINESTRIP = 4'd2,
        MODE_TRI       = 4'd3,
        MODE_TRISTRIP  = 4'd4,
        MODE_FAN       = 4'd5,
        MODE_POLY      = 4'd6,
        MODE_QUAD      = 4'd7,
        MODE_QUADSTRIP = 4'd8
    } prim_mode_t;

    typedef struct packed {
        logic [REF_W-1:0] vertex_ref;
        logic [3:0]       prim_mode;
        logic             list_start;
    } vtx_in_t;

    typedef struct packed {
        logic [REF_W-1:0] out_ref;
        logic             run_last;
    } vtx_out_t;

    // one accepted vertex worth of output references
    typedef struct packed {
        logic [NUM_SLOTS-1:0][REF_W-1:0] refs;
        logic [SLOT_W-1:0]               last_slot;
    } pla_job_t;

endpackage

/* sv/primitive_list_assembler.sv */
// primitive list assembler: turns a stream of vertex references from
// point, line, triangle, strip, fan, polygon and quad lists into
// independent triangle and quad reference lists.
// in channel: in_valid / in_ready / in_data, one vertex per request, with
// its list mode and a flag that marks the first vertex of a list.
// out channel: out_valid / out_ready / out_data, one reference per request,
// run_last set on the final reference caused by one input vertex.
// a vertex is accepted every cycle while the two-entry job queue has room;
// the output side sends one reference per cycle while out_ready is high;
// fans, polygons and triangle strips send three references for each vertex
// from the third on, odd quad-strip vertices from the fourth on send four,
// triangle or quad lists one; modes that emit nothing never enter the queue.
// the references of a vertex pass through the job queue and then the output
// job register before the first of them is offered.
// reset clears list position, parity and vertex history to zero and empties
// the queue; a stalled receiver holds the current reference steady and
// backs up into the queue, then in_ready drops.
module primitive_list_assembler #(
    parameter int REF_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pla_pkg::vtx_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pla_pkg::vtx_out_t out_data
);
    import pla_pkg::*;

    logic     q_full, q_empty, q_push, q_pop;
    pla_job_t push_job, pop_job;

    pla_front #(
        .REF_WIDTH (REF_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    pla_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    pla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sv/pla_front.sv */
module pla_front #(
    parameter int REF_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pla_pkg::vtx_in_t  in_data,
    input  logic              q_full,
    output logic              q_push,
    output pla_pkg::pla_job_t q_job
);
    import pla_pkg::*;

    logic [1:0]           list_position_reg, list_position_next;
    logic                 position_odd_reg, position_odd_next;
    logic [REF_WIDTH-1:0] first_reg, first_next;
    logic [REF_WIDTH-1:0] p1_reg, p2_reg, p3_reg;

    logic                 accept;
    logic [REF_WIDTH-1:0] cur;
    logic [1:0]           pos;
    logic                 odd;
    logic                 emit;
    logic [REF_W-1:0]     cur_w, first_w, p1_w, p2_w, p3_w;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign cur = in_data.vertex_ref[REF_WIDTH-1:0];
    assign pos = in_data.list_start ? 2'd0 : list_position_reg;
    assign odd = in_data.list_start ? 1'b0 : position_odd_reg;

    assign first_next         = (pos == 2'd0) ? cur : first_reg;
    assign list_position_next = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
    assign position_odd_next  = !odd;

    assign cur_w   = REF_W'(cur);
    assign first_w = REF_W'(first_next);
    assign p1_w    = REF_W'(p1_reg);
    assign p2_w    = REF_W'(p2_reg);
    assign p3_w    = REF_W'(p3_reg);

    always_comb
    begin
        emit            = 1'b0;
        q_job.refs      = '0;
        q_job.last_slot = '0;
        case (in_data.prim_mode)
            MODE_TRI, MODE_QUAD:
            begin
                emit             = 1'b1;
                q_job.refs[0]    = cur_w;
                q_job.last_slot  = SLOT_W'(0);
            end
            MODE_FAN, MODE_POLY:
            begin
                emit             = (pos >= 2'd2);
                q_job.refs[0]    = first_w;
                q_job.refs[1]    = p1_w;
                q_job.refs[2]    = cur_w;
                q_job.last_slot  = SLOT_W'(2);
            end
            MODE_TRISTRIP:
            begin
                emit             = (pos >= 2'd2);
                q_job.refs[0]    = odd ? p1_w : p2_w;
                q_job.refs[1]    = odd ? p2_w : p1_w;
                q_job.refs[2]    = cur_w;
                q_job.last_slot  = SLOT_W'(2);
            end
            MODE_QUADSTRIP:
            begin
                emit             = (pos == 2'd3) && odd;
                q_job.refs[0]    = p3_w;
                q_job.refs[1]    = p2_w;
                q_job.refs[2]    = cur_w;
                q_job.refs[3]    = p1_w;
                q_job.last_slot  = SLOT_W'(3);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign q_push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_position_reg <= '0;
            position_odd_reg  <= 1'b0;
            first_reg         <= '0;
            p1_reg            <= '0;
            p2_reg            <= '0;
            p3_reg            <= '0;
        end
        else if (accept)
        begin
            list_position_reg <= list_position_next;
            position_odd_reg  <= position_odd_next;
            first_reg         <= first_next;
            p3_reg            <= p2_reg;
            p2_reg            <= p1_reg;
            p1_reg            <= cur;
        end
    end

endmodule

/* sv/pla_queue.sv */
module pla_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pla_pkg::pla_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output pla_pkg::pla_job_t pop_job
);
    import pla_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    pla_job_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/pla_back.sv */
module pla_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pla_pkg::pla_job_t q_job,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output pla_pkg::vtx_out_t out_data
);
    import pla_pkg::*;

    pla_job_t          job_reg;
    logic              busy_reg, busy_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              out_accept;
    logic              at_last;

    assign at_last    = (slot_reg == job_reg.last_slot);
    assign out_accept = busy_reg && out_ready;

    // take the next job when idle or when the final reference is leaving
    assign q_pop = !q_empty && (!busy_reg || (out_accept && at_last));

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            slot_next = '0;
        end
        else if (out_accept)
        begin
            if (at_last)
                busy_next = 1'b0;
            else
                slot_next = slot_reg + 1'b1;
        end
    end

    assign out_valid         = busy_reg;
    assign out_data.out_ref  = job_reg.refs[slot_reg];
    assign out_data.run_last = at_last;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

endmodule

/* verif/pla_checker.sv */
module pla_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  pla_pkg::vtx_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  pla_pkg::vtx_out_t out_data,
    output int                fail_count,
    output int                pending_refs
);
    timeunit 1ns;
    timeprecision 1ps;
    import pla_pkg::*;

    // list tracking, mirrors what the block keeps between vertices
    logic [1:0]       list_pos;
    logic             pos_odd;
    logic [REF_W-1:0] first_ref;
    logic [REF_W-1:0] hist1;
    logic [REF_W-1:0] hist2;
    logic [REF_W-1:0] hist3;

    vtx_out_t expected_refs[$];

    function automatic void queue_ref(input logic [REF_W-1:0] vref, input logic is_last);
        vtx_out_t r;
        r.out_ref  = vref;
        r.run_last = is_last;
        expected_refs.insert(expected_refs.size(), r);
    endfunction

    function automatic void assemble_vertex(input vtx_in_t v);
        logic [REF_W-1:0] cur;
        logic [REF_W-1:0] first_now;
        logic [1:0]       pos;
        logic             odd;
        cur       = v.vertex_ref;
        pos       = v.list_start ? 2'd0 : list_pos;
        odd       = v.list_start ? 1'b0 : pos_odd;
        first_now = (pos == 2'd0) ? cur : first_ref;
        case (v.prim_mode)
            MODE_TRI, MODE_QUAD:
            begin
                queue_ref(cur, 1'b1);
            end
            MODE_FAN, MODE_POLY:
            begin
                if (pos >= 2'd2)
                begin
                    queue_ref(first_now, 1'b0);
                    queue_ref(hist1, 1'b0);
                    queue_ref(cur, 1'b1);
                end
            end
            MODE_TRISTRIP:
            begin
                if (pos >= 2'd2)
                begin
                    // odd positions swap the two older vertices to keep winding
                    if (odd)
                    begin
                        queue_ref(hist1, 1'b0);
                        queue_ref(hist2, 1'b0);
                    end
                    else
                    begin
                        queue_ref(hist2, 1'b0);
                        queue_ref(hist1, 1'b0);
                    end
                    queue_ref(cur, 1'b1);
                end
            end
            MODE_QUADSTRIP:
            begin
                if (pos == 2'd3 && odd)
                begin
                    queue_ref(hist3, 1'b0);
                    queue_ref(hist2, 1'b0);
                    queue_ref(cur, 1'b0);
                    queue_ref(hist1, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
        first_ref = first_now;
        hist3     = hist2;
        hist2     = hist1;
        hist1     = cur;
        list_pos  = (pos < 2'd3) ? pos + 2'd1 : 2'd3;
        pos_odd   = ~odd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vtx_out_t exp_ref;
        if (!rst_n)
        begin
            list_pos  = '0;
            pos_odd   = 1'b0;
            first_ref = '0;
            hist1     = '0;
            hist2     = '0;
            hist3     = '0;
            expected_refs.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                assemble_vertex(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_refs.size() == 0)
                begin
                    $error("unexpected request out_ref=%h run_last=%b",
                           out_data.out_ref, out_data.run_last);
                    fail_count++;
                end
                else
                begin
                    exp_ref = expected_refs.pop_front();
                    if (out_data.out_ref !== exp_ref.out_ref)
                    begin
                        $error("out_ref expected %h actual %h",
                               exp_ref.out_ref, out_data.out_ref);
                        fail_count++;
                    end
                    if (out_data.run_last !== exp_ref.run_last)
                    begin
                        $error("run_last expected %b actual %b",
                               exp_ref.run_last, out_data.run_last);
                        fail_count++;
                    end
                end
            end
        end
        pending_refs = expected_refs.size();
    end

endmodule

/* verif/tb_primitive_list_assembler.sv */
module tb_primitive_list_assembler;
    timeunit 1ns;
    timeprecision 1ps;
    import pla_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TOTAL_VERTS = 470;
    localparam int STALL_AT    = 150;
    localparam int STALL_LEN   = 400;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    vtx_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    vtx_out_t out_data;

    int fail_count;
    int pending_refs;
    int idle_cycles   = 0;
    int vertices_sent = 0;
    int in_gap_max    = 3;
    int out_gap_max   = 3;

    always #2 clk = ~clk;

    primitive_list_assembler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pla_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending_refs (pending_refs)
    );

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic offer_vertex(input logic [31:0] vref, input logic [3:0] mode,
                                input logic start);
        vtx_in_t v;
        int gap;
        v.vertex_ref = vref;
        v.prim_mode  = mode;
        v.list_start = start;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do @(posedge clk); while (!in_ready);
        vertices_sent++;
    endtask

    // receiver: random hold-offs, plus one long one so the queue backs up
    initial
    begin
        int gap;
        int n_taken;
        n_taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (n_taken == STALL_AT) ? STALL_LEN : $urandom_range(0, out_gap_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_taken++;
        end
    end

    initial
    begin
        logic [3:0]  list_modes [10];
        logic [3:0]  mode;
        logic [3:0]  m;
        logic [31:0] vref;
        int          len;
        list_modes = '{MODE_TRI, MODE_TRISTRIP, MODE_TRISTRIP, MODE_FAN, MODE_POLY,
                       MODE_QUAD, MODE_QUADSTRIP, MODE_QUADSTRIP, MODE_POINT,
                       MODE_LINESTRIP};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fan with no list start since reset
        offer_vertex(32'h0000_0010, MODE_FAN, 1'b0);
        offer_vertex(32'h0000_0011, MODE_FAN, 1'b0);
        offer_vertex(32'h0000_0012, MODE_FAN, 1'b0);
        // triangle list with extreme refs, then an incomplete trailing triangle
        offer_vertex(32'h0000_0000, MODE_TRI, 1'b1);
        offer_vertex(32'hFFFF_FFFF, MODE_TRI, 1'b0);
        offer_vertex(32'h0000_0005, MODE_TRI, 1'b0);
        offer_vertex(32'h0000_000A, MODE_TRI, 1'b1);
        offer_vertex(32'h0000_000B, MODE_TRI, 1'b0);
        // triangle strip, even and odd positions
        offer_vertex(32'h0000_0020, MODE_TRISTRIP, 1'b1);
        offer_vertex(32'h0000_0021, MODE_TRISTRIP, 1'b0);
        offer_vertex(32'h0000_0022, MODE_TRISTRIP, 1'b0);
        offer_vertex(32'h0000_0023, MODE_TRISTRIP, 1'b0);
        // quad strip, two quads
        offer_vertex(32'hFFFF_FFF0, MODE_QUADSTRIP, 1'b1);
        offer_vertex(32'h0000_0031, MODE_QUADSTRIP, 1'b0);
        offer_vertex(32'h0000_0032, MODE_QUADSTRIP, 1'b0);
        offer_vertex(32'h0000_0033, MODE_QUADSTRIP, 1'b0);
        offer_vertex(32'h0000_0034, MODE_QUADSTRIP, 1'b0);
        offer_vertex(32'hFFFF_FFFF, MODE_QUADSTRIP, 1'b0);
        // mode change mid-list keeps history
        offer_vertex(32'h0000_0040, MODE_POLY, 1'b0);
        offer_vertex(32'hFFFF_FFFF, MODE_QUAD, 1'b1);
        // modes that emit nothing, including undefined codes
        offer_vertex(32'hDEAD_BEEF, 4'hF, 1'b1);
        offer_vertex(32'h1234_5678, 4'h9, 1'b0);
        offer_vertex(32'h0000_0001, MODE_POINT, 1'b1);
        offer_vertex(32'h0000_0002, MODE_LINE, 1'b1);
        offer_vertex(32'h0000_0003, MODE_LINESTRIP, 1'b0);

        while (vertices_sent < TOTAL_VERTS)
        begin
            // some stretches run with no idling on either side
            if ($urandom_range(0, 3) == 0)
            begin
                in_gap_max  = 0;
                out_gap_max = 0;
            end
            else
            begin
                in_gap_max  = 3;
                out_gap_max = 3;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                offer_vertex($urandom, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                mode = list_modes[$urandom_range(0, 9)];
                len  = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    vref = $urandom;
                    case ($urandom_range(0, 15))
                        0: vref = '0;
                        1: vref = '1;
                        default: ;
                    endcase
                    m = mode;
                    if ($urandom_range(0, 24) == 0)
                    begin
                        m = 4'($urandom_range(0, 15));
                    end
                    offer_vertex(vref, m, i == 0);
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_refs != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_refs == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
